/* rtl/weighted_histogram_accumulator_core_macros.svh */
// Assertion macros shared by the weighted histogram RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_CORE_MACROS_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WHAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WHAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/whac_pkg.sv */
// Package for the weighted histogram core: widths, register indexes and types.
// Used by the top level; it depends on nothing else.
`default_nettype none

package whac_pkg;

  localparam int MAX_BINS_DEFAULT  = 1024;
  localparam int SUM_WIDTH_DEFAULT = 40;

  localparam int OFFSET_W  = 32;
  localparam int COUNT_W   = 11;
  localparam int SAMPLE_W  = 32;
  localparam int WEIGHT_W  = 17;
  localparam int BINNUM_W  = 10;
  localparam int OUTSUM_W  = 40;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = COUNT_W'(1024);
  localparam logic [63:0]        OUT_SUM_MAX     = 64'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ACCUM    = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_CLR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW
  } state_e;

endpackage

`default_nettype wire

/* rtl/whac_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the bin totals of the histogram core.
`default_nettype none

module whac_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/weighted_histogram_accumulator_core.sv */
// Weighted histogram core. A request is an accumulate, a bin read or a bin read
// and clear; each request yields one result. Configuration is a separate
// write channel with valid and ready; it is always ready.
// Input and output channels use valid and stall. A request is accepted at a
// rising edge with in_valid_i high and in_stall_o low; a result leaves at an
// edge with out_valid_o high and out_stall_i low.
// After reset the core clears the bin memory, one entry per cycle, covering all
// MAX_BINS entries (1024 by default); in_stall_o stays high during that pass.
// Each request is one pass: its bin is read from the memory as it is accepted,
// then in ST_RMW the total is modified, written back and the result register
// loaded. in_stall_o stays high in ST_RMW, so a new request is taken only after
// the single read-modify-write pass through the bin memory for the last one ends.
// While the receiver stalls, the result register holds; a following request
// may still be accepted and waits in its write-back cycle until the register
// frees. Bin totals saturate at SUM_WIDTH bits and are reported clamped to 40 bits.
// Depends on whac_pkg, whac_ram and the assertion macro header.
`default_nettype none

`include "weighted_histogram_accumulator_core_macros.svh"

module weighted_histogram_accumulator_core import whac_pkg::*; #(
  parameter int MAX_BINS  = MAX_BINS_DEFAULT,
  parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [OFFSET_W-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic        [1:0]           opcode_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_value_i,
  input  wire logic        [WEIGHT_W-1:0]  alpha_weight_i,
  input  wire logic        [BINNUM_W-1:0]  read_bin_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             status_o,
  output logic             [BINNUM_W-1:0]  bin_number_o,
  output logic             [OUTSUM_W-1:0]  bin_sum_o
);

  localparam int AW = $clog2(MAX_BINS);
  localparam logic [AW-1:0]        LAST_ADDR = AW'(MAX_BINS - 1);
  localparam logic [32:0]          MAX_BINS_W = 33'(MAX_BINS);
  localparam logic [SUM_WIDTH-1:0] SUM_LIMIT = '1;

  state_e state_q, state_d;

  logic signed [OFFSET_W-1:0] bin_offset_q;
  logic        [COUNT_W-1:0]  bin_count_q;
  logic        [AW-1:0]       clr_q, clr_d;

  logic                op_valid_q;
  logic [1:0]          op_q;
  logic                hit_q, hit_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic [BINNUM_W-1:0] binno_q, binno_d;
  logic [WEIGHT_W-1:0] weight_q;

  logic                out_valid_q;
  logic                status_q;
  logic [BINNUM_W-1:0] out_bin_q;
  logic [OUTSUM_W-1:0] out_sum_q;

  logic                 in_acc;
  logic                 rmw_go;
  logic signed [32:0]   acc_bin;
  logic [32:0]          nbins;
  logic [32:0]          sel_bin;
  logic                 acc_hit, rd_hit;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SUM_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [SUM_WIDTH-1:0] new_total, res_total;
  logic [63:0]          res_wide;
  logic [OUTSUM_W-1:0]  res_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign rmw_go      = (state_q == ST_RMW) && (!out_valid_q || !out_stall_i);

  assign acc_bin = 33'(sample_value_i) + 33'(bin_offset_q);
  assign nbins   = ({22'd0, bin_count_q} > MAX_BINS_W) ? MAX_BINS_W : {22'd0, bin_count_q};
  assign acc_hit = !acc_bin[32] && (unsigned'(acc_bin) < nbins);
  assign rd_hit  = {23'd0, read_bin_i} < nbins;

  always_comb begin
    hit_d   = 1'b0;
    binno_d = '0;
    sel_bin = {23'd0, read_bin_i};
    unique case (op_e'(opcode_i))
      OP_ACCUM: begin
        hit_d   = acc_hit;
        sel_bin = unsigned'(acc_bin);
        binno_d = acc_hit ? acc_bin[BINNUM_W-1:0] : '0;
      end
      OP_READ, OP_READ_CLR: begin
        hit_d   = rd_hit;
        binno_d = read_bin_i;
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
    addr_d = sel_bin[AW-1:0];
  end

  assign sum_ext   = {1'b0, ram_rdata} + (SUM_WIDTH+1)'(weight_q);
  assign new_total = sum_ext[SUM_WIDTH] ? SUM_LIMIT : sum_ext[SUM_WIDTH-1:0];

  always_comb begin
    res_total = ram_rdata;
    if (op_e'(op_q) == OP_ACCUM && weight_q != '0) begin
      res_total = new_total;
    end
    res_wide = 64'(res_total);
    res_sum  = (res_wide > OUT_SUM_MAX) ? OUT_SUM_MAX[OUTSUM_W-1:0] : res_wide[OUTSUM_W-1:0];
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        if (rmw_go) begin
          state_d = ST_IDLE;
          if (hit_q && op_e'(op_q) == OP_ACCUM && weight_q != '0) begin
            ram_we    = 1'b1;
            ram_wdata = new_total;
          end else if (hit_q && op_e'(op_q) == OP_READ_CLR) begin
            ram_we = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_offset_q <= '0;
      bin_count_q  <= BIN_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_BIN_OFFSET) begin
        bin_offset_q <= cfg_data_i;
      end else if (cfg_index_i == REG_BIN_COUNT) begin
        bin_count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (in_acc) begin
      op_valid_q <= 1'b1;
    end else if (rmw_go) begin
      op_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= opcode_i;
      hit_q    <= hit_d;
      addr_q   <= addr_d;
      binno_q  <= binno_d;
      weight_q <= alpha_weight_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rmw_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rmw_go) begin
      status_q  <= !hit_q;
      out_bin_q <= binno_q;
      out_sum_q <= hit_q ? res_sum : '0;
    end
  end

  whac_ram #(
    .WIDTH(SUM_WIDTH),
    .DEPTH(MAX_BINS)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(addr_d),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign bin_number_o = out_bin_q;
  assign bin_sum_o    = out_sum_q;

  `WHAC_ASSERT_IMPL(a_no_accept_in_clear, state_q == ST_CLEAR, in_stall_o, "request accepted during clear")
  `WHAC_ASSERT_IMPL(a_no_write_on_read, ram_we, !in_acc, "bin write collides with a read")
  `WHAC_ASSERT_NEXT(a_accept_to_rmw, in_acc, state_q == ST_RMW && op_valid_q, "accept did not start a pass")
  `WHAC_ASSERT_IMPL(a_miss_sum_zero, out_valid_o && status_o, bin_sum_o == '0, "miss with nonzero sum")

endmodule

`default_nettype wire
